// ----- hdl/fdr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdr_pkg
// Shared widths and defaults for the dielectric Fresnel reflectance block.
// ----------------------------------------------------------------------------
package fdr_pkg;

   localparam int FRAC_BITS_DEF = 15;  // fraction bits of cosines and reflectance
   localparam int RATIO_FRAC    = 12;  // fraction bits of the index ratio
   localparam int IO_W          = 16;  // width of the payload fields

endpackage

// ----- hdl/fdr_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdr_div_cell
// One restoring-division cell: settles one quotient bit and hands the
// remainder, partial quotient and divisor to the next cell.
// ----------------------------------------------------------------------------
module fdr_div_cell #(
   parameter int RW  = 48,
   parameter int DW  = 32,
   parameter int QW  = 16,
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [RW-1:0] rem_i,
   input  logic [QW-1:0] quot_i,
   input  logic [DW-1:0] dvs_i,
   output logic [RW-1:0] rem_o,
   output logic [QW-1:0] quot_o,
   output logic [DW-1:0] dvs_o
);

   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [DW-1:0] dvs_ff;
   logic [RW-1:0] trial;

   assign trial = RW'(dvs_i) << BIT;

   always_comb begin
      rem_in  = rem_i;
      quot_in = quot_i;
      if (rem_i >= trial) begin
         rem_in  = rem_i - trial;
         quot_in = quot_i | (QW'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         dvs_ff  <= dvs_i;
      end
   end

   assign rem_o  = rem_ff;
   assign quot_o = quot_ff;
   assign dvs_o  = dvs_ff;

endmodule

// ----- hdl/fdr_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdr_sqrt_cell
// One restoring square-root cell: settles one root bit per advancing cycle.
// ----------------------------------------------------------------------------
module fdr_sqrt_cell #(
   parameter int RW  = 33,
   parameter int QW  = 16,
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [RW-1:0] rem_i,
   input  logic [QW-1:0] root_i,
   output logic [RW-1:0] rem_o,
   output logic [QW-1:0] root_o
);

   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] root_ff, root_in;
   logic [RW-1:0] trial;

   // higher root bits already in place; test (2*root + 2^BIT) * 2^BIT
   assign trial = (RW'(root_i) << (BIT + 1)) + (RW'(1) << (2 * BIT));

   always_comb begin
      rem_in  = rem_i;
      root_in = root_i;
      if (rem_i >= trial) begin
         rem_in  = rem_i - trial;
         root_in = root_i | (QW'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

// ----- hdl/fdr_delay.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdr_delay
// Side-data shift line that keeps operands in step with a cell chain.
// ----------------------------------------------------------------------------
module fdr_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         advance,
   input  logic [W-1:0] data_i,
   output logic [W-1:0] data_o
);

   logic [W-1:0] data_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff[0] <= data_i;
         for (int k = 1; k < DEPTH; k++) begin
            data_ff[k] <= data_ff[k-1];
         end
      end
   end

   assign data_o = data_ff[DEPTH-1];

endmodule

// ----- hdl/dielectric_fresnel_reflectance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dielectric_fresnel_reflectance
// Fixed-point Fresnel reflectance of a dielectric boundary.
// ----------------------------------------------------------------------------
// Takes one transfer per cycle and returns one result per cycle, in order,
// while the output is not stalled. Most of the pipeline is three rows of bit
// cells: the squared-sine divider (FRAC_BITS cells), the cosine square root
// (FRAC_BITS+1 cells) and the two amplitude-ratio dividers running side by
// side (FRAC_BITS+1 cells), each cell settling one bit. The whole pipeline
// advances together; req_stall rises only while a finished result waits on
// rsp_stall. Total internal reflection returns reflectance one, cosine zero.
// ----------------------------------------------------------------------------
module dielectric_fresnel_reflectance #(
   parameter int FRAC_BITS = fdr_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [fdr_pkg::IO_W-1:0] req_index_ratio,
   input  logic [fdr_pkg::IO_W-1:0] req_cos_known,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [fdr_pkg::IO_W-1:0] rsp_reflectance,
   output logic [fdr_pkg::IO_W-1:0] rsp_cos_other,
   output logic                     rsp_total_reflection
);

   import fdr_pkg::*;

   localparam int F     = FRAC_BITS;
   localparam int LAT   = 3 * F + 8;          // stages ahead of the output register
   localparam int S2W   = 2 * F + 1;          // 1 - c^2 at Q(2F)
   localparam int NW    = F + 25;             // divider-one numerator
   localparam int RW1   = 32 + F;             // divider-one remainder
   localparam int SQW   = 2 * F + 3;          // square-root remainder
   localparam int NCW   = 32 - RATIO_FRAC;    // n*c in Q5.15 at the default FRAC_BITS
   localparam int NCIW  = F + 17 - RATIO_FRAC;
   localparam int PAW   = (F + 1 > NCW) ? F + 1 : NCW;
   localparam int PDW   = PAW + 1;
   localparam int QAW   = (NCIW > IO_W) ? NCIW : IO_W;
   localparam int QDW   = QAW + 1;
   localparam int RWP   = PDW + F + 1;
   localparam int RWQ   = QDW + F + 1;
   localparam int SIDW  = 1 + IO_W + IO_W + NCW;
   localparam int TSH_R = (2 * F >= 2 * RATIO_FRAC) ? 2 * F - 2 * RATIO_FRAC : 0;
   localparam int TSH_L = (2 * F >= 2 * RATIO_FRAC) ? 0 : 2 * RATIO_FRAC - 2 * F;
   localparam int NSH_L = (F <= 2 * RATIO_FRAC) ? 2 * RATIO_FRAC - F : 0;
   localparam int NSH_R = (F <= 2 * RATIO_FRAC) ? 0 : F - 2 * RATIO_FRAC;

   localparam logic [31:0]  ONE32  = 32'(1) << F;
   localparam logic [F:0]   ONE_F  = {1'b1, {F{1'b0}}};
   localparam logic [S2W-1:0] ONE_SQ = {1'b1, {(2 * F){1'b0}}};

   logic advance;
   logic [LAT-1:0] valid_ff;

   // Whole pipeline moves unless the output register holds a stalled result.
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rsp_valid <= 1'b0;
      end else if (advance) begin
         valid_ff  <= {valid_ff[LAT-2:0], req_valid};
         rsp_valid <= valid_ff[LAT-1];
      end
   end

   // ---- stage 1: capture, saturate the cosine at one
   logic [IO_W-1:0] n1_ff, c1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         n1_ff <= req_index_ratio;
         c1_ff <= ({16'b0, req_cos_known} > ONE32) ? ONE32[IO_W-1:0] : req_cos_known;
      end
   end

   // ---- stage 2: squares of the cosine and the ratio
   logic [31:0]     cc2_ff, r2_2_ff;
   logic [IO_W-1:0] n2_ff, c2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         cc2_ff  <= 32'(c1_ff) * 32'(c1_ff);
         r2_2_ff <= 32'(n1_ff) * 32'(n1_ff);
         n2_ff   <= n1_ff;
         c2_ff   <= c1_ff;
      end
   end

   // ---- stage 3: 1 - c^2, total-reflection test, divider numerator, n*c
   logic [S2W-1:0] s2t;
   logic [63:0]    s2t_w, tir_rhs;
   logic [NW-1:0]  num;
   logic [31:0]    ncp;
   logic [NW-1:0]  num3_ff;
   logic [31:0]    r2_3_ff;
   logic           tir3_ff;
   logic [IO_W-1:0] n3_ff, c3_ff;
   logic [NCW-1:0] nc3_ff;

   always_comb begin
      s2t     = ONE_SQ - S2W'(cc2_ff);
      s2t_w   = 64'(s2t);
      tir_rhs = (2 * F >= 2 * RATIO_FRAC) ? (s2t_w >> TSH_R) : (s2t_w << TSH_L);
      num     = (F <= 2 * RATIO_FRAC) ? NW'(s2t_w << NSH_L) : NW'(s2t_w >> NSH_R);
      ncp     = 32'(n2_ff) * 32'(c2_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num3_ff <= num;
         r2_3_ff <= r2_2_ff;
         tir3_ff <= (64'(r2_2_ff) <= tir_rhs);
         n3_ff   <= n2_ff;
         c3_ff   <= c2_ff;
         nc3_ff  <= ncp[31:RATIO_FRAC];
      end
   end

   // ---- divider one: squared sine on the far side, one bit per cell
   logic [RW1-1:0] d1_rem  [0:F];
   logic [F-1:0]   d1_quot [0:F];
   logic [31:0]    d1_dvs  [0:F];

   assign d1_rem[0]  = RW1'(num3_ff);
   assign d1_quot[0] = '0;
   assign d1_dvs[0]  = r2_3_ff;

   for (genvar k = 0; k < F; k++) begin : g_div1
      fdr_div_cell #(.RW(RW1), .DW(32), .QW(F), .BIT(F - 1 - k)) u_cell (
         .clock  (clock),
         .advance(advance),
         .rem_i  (d1_rem[k]),
         .quot_i (d1_quot[k]),
         .dvs_i  (d1_dvs[k]),
         .rem_o  (d1_rem[k+1]),
         .quot_o (d1_quot[k+1]),
         .dvs_o  (d1_dvs[k+1])
      );
   end

   logic [SIDW-1:0] side_a, side_b, side_c;

   assign side_a = {tir3_ff, n3_ff, c3_ff, nc3_ff};

   fdr_delay #(.W(SIDW), .DEPTH(F)) u_side_div1 (
      .clock  (clock),
      .advance(advance),
      .data_i (side_a),
      .data_o (side_b)
   );

   // ---- square root: other-side cosine, one bit per cell
   logic [F:0]     one_minus;
   logic [SQW-1:0] sq_rem  [0:F+1];
   logic [F:0]     sq_root [0:F+1];

   assign one_minus  = ONE_F - {1'b0, d1_quot[F]};
   assign sq_rem[0]  = SQW'(one_minus) << F;
   assign sq_root[0] = '0;

   for (genvar k = 0; k <= F; k++) begin : g_sqrt
      fdr_sqrt_cell #(.RW(SQW), .QW(F + 1), .BIT(F - k)) u_cell (
         .clock  (clock),
         .advance(advance),
         .rem_i  (sq_rem[k]),
         .root_i (sq_root[k]),
         .rem_o  (sq_rem[k+1]),
         .root_o (sq_root[k+1])
      );
   end

   fdr_delay #(.W(SIDW), .DEPTH(F + 1)) u_side_sqrt (
      .clock  (clock),
      .advance(advance),
      .data_i (side_b),
      .data_o (side_c)
   );

   // ---- stage 4: n * cos_other
   logic            tir_c;
   logic [IO_W-1:0] n_c, c_c;
   logic [NCW-1:0]  nc_c;
   logic [F+16:0]   ncip;
   logic            tir4_ff;
   logic [F:0]      ci4_ff;
   logic [NCIW-1:0] nci4_ff;
   logic [NCW-1:0]  nc4_ff;
   logic [IO_W-1:0] c4_ff;

   assign {tir_c, n_c, c_c, nc_c} = side_c;
   assign ncip = (F + 17)'(n_c) * (F + 17)'(sq_root[F+1]);

   always_ff @(posedge clock) begin
      if (advance) begin
         tir4_ff <= tir_c;
         ci4_ff  <= sq_root[F+1];
         nci4_ff <= ncip[F+16:RATIO_FRAC];
         nc4_ff  <= nc_c;
         c4_ff   <= c_c;
      end
   end

   // ---- stage 5: magnitudes and sums of the two amplitude ratios
   logic [PAW-1:0] pa, pb;
   logic [QAW-1:0] qa, qb;
   logic [PAW-1:0] pdiff5_ff;
   logic [PDW-1:0] pden5_ff;
   logic [QAW-1:0] qdiff5_ff;
   logic [QDW-1:0] qden5_ff;
   logic           pz5_ff, qz5_ff, tir5_ff;
   logic [F:0]     ci5_ff;

   always_comb begin
      pa = PAW'(ci4_ff);
      pb = PAW'(nc4_ff);
      qa = QAW'(nci4_ff);
      qb = QAW'(c4_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pdiff5_ff <= (pa >= pb) ? pa - pb : pb - pa;
         pden5_ff  <= PDW'(pa) + PDW'(pb);
         pz5_ff    <= (pa == '0) && (pb == '0);
         qdiff5_ff <= (qa >= qb) ? qa - qb : qb - qa;
         qden5_ff  <= QDW'(qa) + QDW'(qb);
         qz5_ff    <= (qa == '0) && (qb == '0);
         tir5_ff   <= tir4_ff;
         ci5_ff    <= ci4_ff;
      end
   end

   // ---- dividers two and three: parallel and perpendicular ratios
   logic [RWP-1:0] dp_rem  [0:F+1];
   logic [F:0]     dp_quot [0:F+1];
   logic [PDW-1:0] dp_dvs  [0:F+1];
   logic [RWQ-1:0] dq_rem  [0:F+1];
   logic [F:0]     dq_quot [0:F+1];
   logic [QDW-1:0] dq_dvs  [0:F+1];

   assign dp_rem[0]  = RWP'(pdiff5_ff) << F;
   assign dp_quot[0] = '0;
   assign dp_dvs[0]  = pden5_ff;
   assign dq_rem[0]  = RWQ'(qdiff5_ff) << F;
   assign dq_quot[0] = '0;
   assign dq_dvs[0]  = qden5_ff;

   for (genvar k = 0; k <= F; k++) begin : g_div2
      fdr_div_cell #(.RW(RWP), .DW(PDW), .QW(F + 1), .BIT(F - k)) u_pcell (
         .clock  (clock),
         .advance(advance),
         .rem_i  (dp_rem[k]),
         .quot_i (dp_quot[k]),
         .dvs_i  (dp_dvs[k]),
         .rem_o  (dp_rem[k+1]),
         .quot_o (dp_quot[k+1]),
         .dvs_o  (dp_dvs[k+1])
      );
      fdr_div_cell #(.RW(RWQ), .DW(QDW), .QW(F + 1), .BIT(F - k)) u_qcell (
         .clock  (clock),
         .advance(advance),
         .rem_i  (dq_rem[k]),
         .quot_i (dq_quot[k]),
         .dvs_i  (dq_dvs[k]),
         .rem_o  (dq_rem[k+1]),
         .quot_o (dq_quot[k+1]),
         .dvs_o  (dq_dvs[k+1])
      );
   end

   logic [F+3:0] side_d, side_e;
   logic         tir_e, pz_e, qz_e;
   logic [F:0]   ci_e;

   assign side_d = {tir5_ff, pz5_ff, qz5_ff, ci5_ff};

   fdr_delay #(.W(F + 4), .DEPTH(F + 1)) u_side_div2 (
      .clock  (clock),
      .advance(advance),
      .data_i (side_d),
      .data_o (side_e)
   );

   assign {tir_e, pz_e, qz_e, ci_e} = side_e;

   // ---- stage 6: square both ratios; a zero denominator reads as one
   logic [F:0]     p_val, q_val;
   logic [2*F+1:0] pp6_ff, qq6_ff;
   logic           tir6_ff;
   logic [F:0]     ci6_ff;

   assign p_val = pz_e ? ONE_F : dp_quot[F+1];
   assign q_val = qz_e ? ONE_F : dq_quot[F+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         pp6_ff  <= (2 * F + 2)'(p_val) * (2 * F + 2)'(p_val);
         qq6_ff  <= (2 * F + 2)'(q_val) * (2 * F + 2)'(q_val);
         tir6_ff <= tir_e;
         ci6_ff  <= ci_e;
      end
   end

   // ---- output register: half the sum, saturate, select total reflection
   logic [F+1:0] sum;
   logic [F:0]   half, refl;

   always_comb begin
      sum  = (F + 2)'(pp6_ff >> F) + (F + 2)'(qq6_ff >> F);
      half = sum[F+1:1];
      refl = (half > ONE_F) ? ONE_F : half;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_total_reflection <= tir6_ff;
         rsp_reflectance      <= tir6_ff ? ONE32[IO_W-1:0] : IO_W'(refl);
         rsp_cos_other        <= tir6_ff ? '0 : IO_W'(ci6_ff);
      end
   end

   // ---- checks
   a_tir_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_total_reflection |->
         rsp_reflectance == ONE32[IO_W-1:0] && rsp_cos_other == '0)
      else $error("total reflection result malformed");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input held without output backpressure");

   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(valid_ff))
      else $error("pipeline moved while output stalled");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dielectric Fresnel reflectance block.
// ----------------------------------------------------------------------------
// Drives index-ratio / cosine pairs through the request channel, predicts the
// reflectance, other-side cosine and total-reflection flag of each one with an
// exact integer model, and compares every response transfer in order against
// the queue of predicted results. Both channels idle at random; one phase
// holds the response side off long enough to back the pipeline up.
// ----------------------------------------------------------------------------
module testbench;

   import fdr_pkg::*;

   localparam int FB       = FRAC_BITS_DEF;
   localparam int LATENCY  = 3 * FB + 9;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic [IO_W-1:0] reflectance;
      logic [IO_W-1:0] cos_other;
      logic            total_reflection;
   } fresnel_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic [IO_W-1:0] req_index_ratio = '0;
   logic [IO_W-1:0] req_cos_known = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b1;
   logic [IO_W-1:0] rsp_reflectance;
   logic [IO_W-1:0] rsp_cos_other;
   logic            rsp_total_reflection;

   fresnel_type pending_results[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          no_idle = 1'b0;   // suppress random gaps on both sides
   bit          hold_off = 1'b0;  // request a long receiver stall

   always #5 clock = ~clock;

   dielectric_fresnel_reflectance i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_index_ratio      (req_index_ratio),
      .req_cos_known        (req_cos_known),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_reflectance      (rsp_reflectance),
      .rsp_cos_other        (rsp_cos_other),
      .rsp_total_reflection (rsp_total_reflection)
   );

   // Integer square root, floor, bit by bit.
   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // floor(|a-b| * ONE / (a+b)); ONE on a zero denominator.
   function automatic logic [63:0] amplitude_ratio(logic [63:0] a, logic [63:0] b);
      logic [63:0] diff;
      diff = (a >= b) ? a - b : b - a;
      if (a + b == 0) return 64'd1 << FB;
      return (diff << FB) / (a + b);
   endfunction

   function automatic fresnel_type predict_fresnel(logic [IO_W-1:0] ratio,
                                                   logic [IO_W-1:0] cosk);
      fresnel_type r;
      logic [63:0] one, n, c, s2t, r2, s2i, ci, nc, nci, p, q, sum;
      one = 64'd1 << FB;
      n   = 64'(ratio);
      c   = (64'(cosk) > one) ? one : 64'(cosk);
      s2t = one * one - c * c;
      r2  = n * n;
      // Compare at Q24: squared sine reaches one exactly when r2 fits under it.
      if (r2 <= (s2t >> (2 * FB - 2 * RATIO_FRAC))) begin
         r.reflectance      = one[IO_W-1:0];
         r.cos_other        = '0;
         r.total_reflection = 1'b1;
         return r;
      end
      s2i = (s2t << (2 * RATIO_FRAC - FB)) / r2;
      if (s2i > one) s2i = one;
      ci  = floor_sqrt((one - s2i) << FB);
      nc  = (n * c) >> RATIO_FRAC;
      nci = (n * ci) >> RATIO_FRAC;
      p   = amplitude_ratio(ci, nc);
      q   = amplitude_ratio(nci, c);
      sum = (((p * p) >> FB) + ((q * q) >> FB)) >> 1;
      if (sum > one) sum = one;
      r.reflectance      = sum[IO_W-1:0];
      r.cos_other        = ci[IO_W-1:0];
      r.total_reflection = 1'b0;
      return r;
   endfunction

   // Idle at random, then offer one item and hold it until the transfer.
   task automatic send_item(logic [IO_W-1:0] ratio, logic [IO_W-1:0] cosk);
      while (!no_idle && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_index_ratio <= ratio;
      req_cos_known   <= cosk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(predict_fresnel(ratio, cosk));
      @(negedge clock);
   endtask

   // Receiver: random stall, or a long counted hold-off when requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 15);
      end
   end

   // Check each response transfer against the oldest prediction.
   always @(posedge clock) begin
      fresnel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("response with no prediction pending");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_reflectance !== want.reflectance) begin
               $error("reflectance exp %0d got %0d", want.reflectance, rsp_reflectance);
               error_count++;
            end
            if (rsp_cos_other !== want.cos_other) begin
               $error("cos_other exp %0d got %0d", want.cos_other, rsp_cos_other);
               error_count++;
            end
            if (rsp_total_reflection !== want.total_reflection) begin
               $error("total_reflection exp %0b got %0b",
                      want.total_reflection, rsp_total_reflection);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count cycles without any transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("FAIL dielectric_fresnel_reflectance");
            $finish;
         end
      end
   end

   // Extremes, saturated cosine, total reflection, unity ratio.
   task automatic test_directed();
      send_item(16'd1, 16'd0);
      send_item(16'd1, 16'd32768);
      send_item(16'hFFFF, 16'd0);
      send_item(16'hFFFF, 16'd32768);
      send_item(16'hFFFF, 16'hFFFF);
      send_item(16'd4096, 16'hFFFF);
      send_item(16'd4096, 16'd32768);
      send_item(16'd4096, 16'd0);
      send_item(16'd4096, 16'd23170);
      send_item(16'd2731, 16'd16384);
      send_item(16'd2731, 16'd30000);
      send_item(16'd6144, 16'd1);
      send_item(16'd6144, 16'd32767);
      send_item(16'd4095, 16'd100);
      send_item(16'd4097, 16'd100);
      send_item(16'h8000, 16'h7FFF);
      send_item(16'h5555, 16'hAAAA);
      send_item(16'hAAAA, 16'h5555);
   endtask

   // Random items, mostly physical ratios near one and in-range cosines.
   task automatic test_random(int count);
      logic [IO_W-1:0] ratio, cosk;
      repeat (count) begin
         case ($urandom_range(9))
            0:       ratio = IO_W'($urandom_range(65535, 1));
            1:       ratio = IO_W'($urandom_range(4096, 1));
            default: ratio = IO_W'($urandom_range(10240, 2048));
         endcase
         cosk = ($urandom_range(9) == 0) ? IO_W'($urandom_range(65535, 0))
                                         : IO_W'($urandom_range(32768, 0));
         send_item(ratio, cosk);
      end
   endtask

   // Back-pressure: hold the receiver off while the sender keeps offering.
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (3 * LATENCY) @(posedge clock);
            hold_off = 1'b0;
         end
         test_random(4 * LATENCY);
      join
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(600);
      no_idle = 1'b1;
      test_random(400);
      no_idle = 1'b0;
      test_backpressure();
      test_random(600);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASS dielectric_fresnel_reflectance");
      end else begin
         $display("FAIL dielectric_fresnel_reflectance");
      end
      $finish;
   end

endmodule
